// ===== rtl/dwpsf_pkg.sv =====
`timescale 1ns / 1ps

package dwpsf_pkg;

	localparam int TS_W       = 32;
	localparam int SPEED_W    = 17;
	localparam int ALPHA_W    = 17;
	localparam int ALPHA_FRAC = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_WINDOW_COUNT_BITS = 16;
	localparam int DEF_FILTER_FRAC_BITS  = 16;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE       = ALPHA_W'(1 << ALPHA_FRAC);
	localparam logic [TS_W-1:0]    DEBOUNCE_RESET  = TS_W'(36000);
	localparam logic [ALPHA_W-1:0] ALPHA_RESET     = ALPHA_W'(13107);

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = CFG_IDX_W'(1);

	typedef struct packed {
		logic step;
		logic rd;
		logic clr;
	} dwpsf_ctrl_t;

endpackage

// ===== rtl/dwpsf_wheel.sv =====
`timescale 1ns / 1ps

module dwpsf_wheel import dwpsf_pkg::*; #(
	parameter int WINDOW_COUNT_BITS = DEF_WINDOW_COUNT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dwpsf_ctrl_t                  ctrl,
	input  logic                         edge_in,
	input  logic [TS_W-1:0]              now,
	input  logic [TS_W-1:0]              window,
	output logic [WINDOW_COUNT_BITS-1:0] win_count,
	output logic [TS_W-1:0]              total
);

	localparam logic [WINDOW_COUNT_BITS-1:0] WIN_MAX = '1;

	logic [TS_W-1:0]              last_q;
	logic [WINDOW_COUNT_BITS-1:0] win_q;
	logic [TS_W-1:0]              total_q;
	logic [TS_W-1:0]              gap;
	logic                         hit;
	logic [WINDOW_COUNT_BITS-1:0] win_base;
	logic [WINDOW_COUNT_BITS-1:0] win_next;
	logic [TS_W-1:0]              total_next;

	// wrapping gap since the last counted edge
	assign gap = now - last_q;
	assign hit = edge_in && (gap > window);

	// a read empties the window before this item's edge lands
	assign win_base   = ctrl.rd ? '0 : win_q;
	assign win_next   = (hit && (win_base != WIN_MAX)) ? win_base + 1'b1 : win_base;
	assign total_next = ctrl.clr ? '0 : total_q + TS_W'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			win_q   <= '0;
			total_q <= '0;
		end else if (ctrl.step) begin
			win_q   <= win_next;
			total_q <= total_next;
			if (hit) begin
				last_q <= now;
			end
		end
	end

	assign win_count = win_q;
	assign total     = total_q;

endmodule

// ===== rtl/dwpsf_iir.sv =====
`timescale 1ns / 1ps

module dwpsf_iir import dwpsf_pkg::*; #(
	parameter int WINDOW_COUNT_BITS = DEF_WINDOW_COUNT_BITS,
	parameter int FILTER_FRAC_BITS  = DEF_FILTER_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dwpsf_ctrl_t                  ctrl,
	input  logic [ALPHA_W-1:0]           alpha,
	input  logic [WINDOW_COUNT_BITS-1:0] left_count,
	input  logic [WINDOW_COUNT_BITS-1:0] right_count,
	output logic [SPEED_W-1:0]           speed
);

	localparam int X_W   = WINDOW_COUNT_BITS + 1;
	localparam int FV_W  = X_W + FILTER_FRAC_BITS;
	localparam int P1_W  = ALPHA_W + X_W;
	localparam int P2_W  = ALPHA_W + FV_W;
	localparam int ACC_W = P2_W + 1;
	localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (ALPHA_FRAC - 1);
	localparam logic [FV_W:0]    OUT_HALF = (FV_W + 1)'(1) << (FILTER_FRAC_BITS - 1);

	logic [FV_W-1:0]    fv_q;
	logic [X_W-1:0]     x;
	logic [ALPHA_W-1:0] beta;
	logic [P1_W-1:0]    p1;
	logic [P2_W-1:0]    p2;
	logic [ACC_W-1:0]   acc;
	logic [FV_W-1:0]    fv_next;
	logic [FV_W:0]      rsum;

	assign x    = {1'b0, left_count} + {1'b0, right_count};
	assign beta = ALPHA_ONE - alpha;

	// alpha*(x << frac) taken as (alpha*x) << frac
	assign p1  = P1_W'(alpha) * P1_W'(x);
	assign p2  = P2_W'(beta) * P2_W'(fv_q);
	assign acc = (ACC_W'(p1) << FILTER_FRAC_BITS) + ACC_W'(p2) + ACC_HALF;

	assign fv_next = FV_W'(acc >> ALPHA_FRAC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
		end else if (ctrl.step && ctrl.rd) begin
			fv_q <= fv_next;
		end
	end

	// round half up to a whole count
	assign rsum  = {1'b0, fv_q} + OUT_HALF;
	assign speed = SPEED_W'(rsum >> FILTER_FRAC_BITS);

endmodule

// ===== rtl/debounced_wheel_pulse_speed_filter.sv =====
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_ready  | timestamp, left_edge, right_edge, read_strobe, clear_totals
// out     | out_valid/ out_ready | speed_valid, filtered_speed, left_total, right_total
// cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data (always ready)
//
// one item per cycle while the result is not stalled: an item is held in the
// input register, then the debounce compare, counters and the filter
// multiply-add update the state and the result register together.
// reset clears all counters, the filter and the result register, and loads
// the register defaults. a stalled result holds the input register; a new
// item is still taken in the cycle the result leaves.

module debounced_wheel_pulse_speed_filter import dwpsf_pkg::*; #(
	parameter int WINDOW_COUNT_BITS = DEF_WINDOW_COUNT_BITS,
	parameter int FILTER_FRAC_BITS  = DEF_FILTER_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TS_W-1:0]       timestamp,
	input  logic                  left_edge,
	input  logic                  right_edge,
	input  logic                  read_strobe,
	input  logic                  clear_totals,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  speed_valid,
	output logic [SPEED_W-1:0]    filtered_speed,
	output logic [TS_W-1:0]       left_total,
	output logic [TS_W-1:0]       right_total,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [TS_W-1:0]    window_q;
	logic [ALPHA_W-1:0] alpha_q;

	logic               v_s1;
	logic [TS_W-1:0]    ts_s1;
	logic               le_s1;
	logic               re_s1;
	logic               rd_s1;
	logic               clr_s1;

	logic               out_v_q;
	logic               spd_v_q;
	logic               advance;
	dwpsf_ctrl_t        ctrl;

	logic [WINDOW_COUNT_BITS-1:0] left_win;
	logic [WINDOW_COUNT_BITS-1:0] right_win;
	logic [ALPHA_W-1:0]           alpha_wr;

	assign cfg_ready = 1'b1;
	// alpha above one is held at one
	assign alpha_wr  = (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE : cfg_data[ALPHA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= DEBOUNCE_RESET;
			alpha_q  <= ALPHA_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE: window_q <= cfg_data[TS_W-1:0];
				REG_ALPHA:    alpha_q  <= alpha_wr;
				default: ;
			endcase
		end
	end

	assign advance  = v_s1 && (!out_v_q || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ts_s1  <= timestamp;
			le_s1  <= left_edge;
			re_s1  <= right_edge;
			rd_s1  <= read_strobe;
			clr_s1 <= clear_totals;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			spd_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
			spd_v_q <= rd_s1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign ctrl.step = advance;
	assign ctrl.rd   = rd_s1;
	assign ctrl.clr  = clr_s1;

	dwpsf_wheel #(
		.WINDOW_COUNT_BITS(WINDOW_COUNT_BITS)
	) u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.edge_in   (le_s1),
		.now       (ts_s1),
		.window    (window_q),
		.win_count (left_win),
		.total     (left_total)
	);

	dwpsf_wheel #(
		.WINDOW_COUNT_BITS(WINDOW_COUNT_BITS)
	) u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.edge_in   (re_s1),
		.now       (ts_s1),
		.window    (window_q),
		.win_count (right_win),
		.total     (right_total)
	);

	dwpsf_iir #(
		.WINDOW_COUNT_BITS(WINDOW_COUNT_BITS),
		.FILTER_FRAC_BITS (FILTER_FRAC_BITS)
	) u_iir (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.alpha       (alpha_q),
		.left_count  (left_win),
		.right_count (right_win),
		.speed       (filtered_speed)
	);

	assign out_valid   = out_v_q;
	assign speed_valid = spd_v_q;

endmodule
